@@ hdl/mpr_pkg.sv @@
// mpr_pkg: shared widths, reset values, register indexes and stage payload types
// for the masked pixel to rgba8 converter. no dependencies.

package mpr_pkg;

    localparam int MASK_W         = 32;
    localparam int PIXEL_BITS_DEF = 32;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int QUO_W          = CH_W;
    localparam int NUM_W          = MASK_W + QUO_W;
    localparam int SH_W           = $clog2(MASK_W);
    localparam int IDX_W          = 2;

    localparam logic [MASK_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [MASK_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [MASK_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [CH_W-1:0]   ALPHA_OPAQUE   = 8'hFF;

    typedef enum logic [IDX_W-1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2
    } cfg_reg_t;

    typedef logic [MASK_W-1:0] mask_t;
    typedef mask_t [NUM_CH-1:0] mask_set_t;

    // channel bits shifted down, with the shifted mask as divisor
    typedef struct packed {
        logic [MASK_W-1:0] val;
        logic [MASK_W-1:0] max;
        logic              zero;
    } chan_unp_t;

    // partial remainder and quotient of the rounding division
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [MASK_W-1:0] max;
        logic [QUO_W-1:0]  quo;
        logic              zero;
    } chan_div_t;

    typedef chan_unp_t [NUM_CH-1:0] unp_item_t;
    typedef chan_div_t [NUM_CH-1:0] div_item_t;

    // trailing zero count, zero for an empty mask
    function automatic logic [SH_W-1:0] trail_zeros(input logic [MASK_W-1:0] m);
        logic [SH_W-1:0] n;
        n = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = SH_W'(i);
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/mpr_pixel_if.sv @@
// mpr_pixel_if: valid/ready channel carrying one packed pixel word per item.
// no dependencies.

interface mpr_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

@@ hdl/mpr_rgba_if.sv @@
// mpr_rgba_if: valid/ready channel carrying one 8-bit rgba result per item.
// no dependencies.

interface mpr_rgba_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

@@ hdl/mpr_unpack.sv @@
// mpr_unpack: pipeline stage that extracts each channel's bits under its mask
// and shifts them and the mask down to bit 0. depends on mpr_pkg.

module mpr_unpack #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic [PIXEL_BITS-1:0]    pixel,
    input  mpr_pkg::mask_set_t       masks,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output mpr_pkg::unp_item_t       item
);

    localparam int MW = mpr_pkg::MASK_W;

    logic [MW-1:0]       pix_wide;
    mpr_pkg::unp_item_t  item_next;
    mpr_pkg::unp_item_t  item_reg;
    logic                valid_reg;

    assign pix_wide = MW'(pixel);

    always_comb
    begin
        for (int ch = 0; ch < mpr_pkg::NUM_CH; ch++)
        begin
            item_next[ch].val  = (pix_wide & masks[ch]) >> mpr_pkg::trail_zeros(masks[ch]);
            item_next[ch].max  = masks[ch] >> mpr_pkg::trail_zeros(masks[ch]);
            item_next[ch].zero = (masks[ch] == '0);
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign item     = item_reg;

    // masked bits shifted down can never exceed the shifted mask
    for (genvar ch = 0; ch < mpr_pkg::NUM_CH; ch++)
    begin : g_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg && !item_reg[ch].zero |-> item_reg[ch].val <= item_reg[ch].max)
            else $error("unpacked channel value above its maximum");
    end

endmodule

@@ hdl/mpr_numer.sv @@
// mpr_numer: pipeline stage that forms the rounding numerator v*255 + max/2
// for each channel. depends on mpr_pkg.

module mpr_numer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  mpr_pkg::unp_item_t   up_item,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output mpr_pkg::div_item_t   item
);

    localparam int NW = mpr_pkg::NUM_W;
    localparam int QW = mpr_pkg::QUO_W;

    mpr_pkg::div_item_t  item_next;
    mpr_pkg::div_item_t  item_reg;
    logic                valid_reg;

    // v*255 as v*256 - v
    always_comb
    begin
        for (int ch = 0; ch < mpr_pkg::NUM_CH; ch++)
        begin
            item_next[ch].rem  = {up_item[ch].val, {QW{1'b0}}} - NW'(up_item[ch].val)
                               + NW'(up_item[ch].max >> 1);
            item_next[ch].max  = up_item[ch].max;
            item_next[ch].quo  = '0;
            item_next[ch].zero = up_item[ch].zero;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign item     = item_reg;

endmodule

@@ hdl/mpr_div_step.sv @@
// mpr_div_step: one restoring division stage, resolving quotient bit BIT of
// each channel's scaled value. depends on mpr_pkg.

module mpr_div_step #(
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  mpr_pkg::div_item_t   up_item,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output mpr_pkg::div_item_t   item
);

    localparam int NW = mpr_pkg::NUM_W;

    logic [NW-1:0] divs [mpr_pkg::NUM_CH];
    mpr_pkg::div_item_t  item_next;
    mpr_pkg::div_item_t  item_reg;
    logic                valid_reg;

    always_comb
    begin
        item_next = up_item;
        for (int ch = 0; ch < mpr_pkg::NUM_CH; ch++)
        begin
            divs[ch] = NW'(up_item[ch].max) << BIT;
            if (up_item[ch].rem >= divs[ch])
            begin
                item_next[ch].rem      = up_item[ch].rem - divs[ch];
                item_next[ch].quo[BIT] = 1'b1;
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign item     = item_reg;

    // remainder stays below the divisor at this bit position
    for (genvar ch = 0; ch < mpr_pkg::NUM_CH; ch++)
    begin : g_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg && !item_reg[ch].zero |->
                item_reg[ch].rem < (NW'(item_reg[ch].max) << BIT))
            else $error("division remainder out of bound");
    end

endmodule

@@ hdl/masked_pixel_to_rgba8.sv @@
// masked_pixel_to_rgba8: top level, mask registers, input capture, division
// pipeline and output register. depends on mpr_pkg, mpr_pixel_if, mpr_rgba_if,
// mpr_unpack, mpr_numer and mpr_div_step.
//
// usage: packed pixel words come in on pix, one per item; each gives one rgba
// item on rgba. the three channel masks are written through cfg_write,
// cfg_index and cfg_data while no item is in flight; an index of three is ignored.
// every stage is a valid/ready register: input capture, mask unpack, numerator,
// eight division stages (one quotient bit each), output register.
// throughput: one item per cycle while rgba.ready stays high, since the divider
// resolves one quotient bit per stage; a new item may be taken before the
// previous one reaches rgba.
// reset: masks return to red 0x00ff0000, green 0x0000ff00, blue 0x000000ff
// and the pipeline empties.
// stall: while rgba.ready is low the output item holds, items behind it
// close up empty stages, and pix.ready drops only once every stage is full.

module masked_pixel_to_rgba8 #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mpr_pixel_if.sink                    pix,
    mpr_rgba_if.source                   rgba,
    input  logic                         cfg_write,
    input  logic [mpr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mpr_pkg::MASK_W-1:0]   cfg_data
);

    localparam int QW = mpr_pkg::QUO_W;

    logic [mpr_pkg::MASK_W-1:0] red_mask_reg;
    logic [mpr_pkg::MASK_W-1:0] green_mask_reg;
    logic [mpr_pkg::MASK_W-1:0] blue_mask_reg;
    mpr_pkg::mask_set_t         masks;

    logic                       pix_valid_reg;
    logic [PIXEL_BITS-1:0]      pix_reg;
    logic                       pix_ready;

    logic                       unp_valid;
    logic                       unp_ready;
    mpr_pkg::unp_item_t         unp_item;

    logic                       stage_valid [QW+1];
    logic                       stage_ready [QW+2];
    mpr_pkg::div_item_t         stage_item  [QW+1];

    logic                       out_valid_reg;
    logic                       out_ready;
    logic [mpr_pkg::CH_W-1:0]   red_reg;
    logic [mpr_pkg::CH_W-1:0]   green_reg;
    logic [mpr_pkg::CH_W-1:0]   blue_reg;
    mpr_pkg::div_item_t         last_item;

    // mask registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_mask_reg   <= mpr_pkg::RED_MASK_RST;
            green_mask_reg <= mpr_pkg::GREEN_MASK_RST;
            blue_mask_reg  <= mpr_pkg::BLUE_MASK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mpr_pkg::REG_RED_MASK:   red_mask_reg   <= cfg_data;
                mpr_pkg::REG_GREEN_MASK: green_mask_reg <= cfg_data;
                mpr_pkg::REG_BLUE_MASK:  blue_mask_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign masks[0] = red_mask_reg;
    assign masks[1] = green_mask_reg;
    assign masks[2] = blue_mask_reg;

    // input capture, only the low pixel bits are kept
    assign pix_ready = !pix_valid_reg || unp_ready;
    assign pix.ready = pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            pix_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix.valid)
        begin
            pix_reg <= pix.pixel[PIXEL_BITS-1:0];
        end
    end

    mpr_unpack #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_unpack (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid_reg),
        .up_ready (unp_ready),
        .pixel    (pix_reg),
        .masks    (masks),
        .dn_valid (unp_valid),
        .dn_ready (stage_ready[0]),
        .item     (unp_item)
    );

    mpr_numer u_numer (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (unp_valid),
        .up_ready (stage_ready[0]),
        .up_item  (unp_item),
        .dn_valid (stage_valid[0]),
        .dn_ready (stage_ready[1]),
        .item     (stage_item[0])
    );

    // quotient bits from the top down
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        mpr_div_step #(
            .BIT (QW - 1 - i)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i+1]),
            .up_item  (stage_item[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+2]),
            .item     (stage_item[i+1])
        );
    end

    // the last division stage hands to the output register
    assign last_item = stage_item[QW];
    assign stage_ready[QW+1] = out_ready;
    assign out_ready = !out_valid_reg || rgba.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= stage_valid[QW];
        end
    end

    // a zero mask gives zero
    always_ff @(posedge clk)
    begin
        if (out_ready && stage_valid[QW])
        begin
            red_reg   <= last_item[0].zero ? '0 : last_item[0].quo;
            green_reg <= last_item[1].zero ? '0 : last_item[1].quo;
            blue_reg  <= last_item[2].zero ? '0 : last_item[2].quo;
        end
    end

    assign rgba.valid = out_valid_reg;
    assign rgba.red   = red_reg;
    assign rgba.green = green_reg;
    assign rgba.blue  = blue_reg;
    assign rgba.alpha = mpr_pkg::ALPHA_OPAQUE;

    // with the output empty, every stage must be able to take an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pix_ready)
        else $error("input blocked while output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == mpr_pkg::REG_RED_MASK) |=>
            red_mask_reg == $past(cfg_data))
        else $error("red mask write not taken");

endmodule

@@ verif/masked_pixel_to_rgba8_tb.sv @@
// masked_pixel_to_rgba8_tb: self-checking bench for the masked pixel to rgba8 converter.
// needs mpr_pkg, mpr_pixel_if, mpr_rgba_if and masked_pixel_to_rgba8 from hdl.
// directed and random pixels and channel masks are scored against a channel scaling predictor.

`timescale 1ns / 100ps

module masked_pixel_to_rgba8_tb;

    // index past the last mask register, writes to it are dropped
    localparam logic [mpr_pkg::IDX_W-1:0] REG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba8_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [mpr_pkg::IDX_W-1:0] cfg_index;
    logic [mpr_pkg::MASK_W-1:0] cfg_data;

    mpr_pixel_if pix_ch();
    mpr_rgba_if  rgba_ch();

    masked_pixel_to_rgba8 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .rgba      (rgba_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mpr_pkg::mask_t red_mask_q;
    mpr_pkg::mask_t green_mask_q;
    mpr_pkg::mask_t blue_mask_q;
    rgba8_t expected_rgba[$];
    int errors;
    bit steady;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("masked_pixel_to_rgba8 regression: fail");
        $finish;
    end

    // selected bits shifted down, rounded onto 0..255
    function automatic logic [7:0] channel_to_8bit(mpr_pkg::mask_t mask,
                                                   logic [31:0] pixel_word);
        logic [63:0] span;
        logic [63:0] level;
        logic [63:0] rounded;
        if (mask == '0)
            return 8'd0;
        span  = 64'(mask);
        level = 64'(pixel_word & mask);
        while (span[0] == 1'b0)
        begin
            span  = span >> 1;
            level = level >> 1;
        end
        if (span == 64'd255)
            return level[7:0];
        rounded = (level * 64'd255 + span / 64'd2) / span;
        return rounded[7:0];
    endfunction

    function automatic rgba8_t pixel_to_rgba(logic [31:0] pixel_word);
        rgba8_t c;
        c.red   = channel_to_8bit(red_mask_q, pixel_word);
        c.green = channel_to_8bit(green_mask_q, pixel_word);
        c.blue  = channel_to_8bit(blue_mask_q, pixel_word);
        c.alpha = mpr_pkg::ALPHA_OPAQUE;
        return c;
    endfunction

    function automatic mpr_pkg::mask_t random_mask();
        int sel;
        int w;
        int lo;
        logic [63:0] field;
        sel = $urandom_range(0, 10);
        unique case (sel)
            6: return '0;
            7: return '1;
            8: return $urandom() & $urandom();
            9: return $urandom();
            10:
            begin
                lo = $urandom_range(0, 24);
                return mpr_pkg::mask_t'(64'hFF << lo);
            end
            default:
            begin
                w  = $urandom_range(1, 32);
                lo = $urandom_range(0, 32 - w);
                field = ((64'd1 << w) - 64'd1) << lo;
                return field[31:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] random_pixel();
        int sel;
        sel = $urandom_range(0, 9);
        unique case (sel)
            0: return '1;
            1: return '0;
            2: return red_mask_q | green_mask_q | blue_mask_q;
            default: return $urandom();
        endcase
    endfunction

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_rgba();
        rgba8_t want;
        if (expected_rgba.size() == 0)
        begin
            $display("%0t: unexpected item, expected none, actual r %0d g %0d b %0d a %0d",
                     $time, rgba_ch.red, rgba_ch.green, rgba_ch.blue, rgba_ch.alpha);
            errors++;
        end
        else
        begin
            want = expected_rgba.pop_front();
            check_channel("red", want.red, rgba_ch.red);
            check_channel("green", want.green, rgba_ch.green);
            check_channel("blue", want.blue, rgba_ch.blue);
            check_channel("alpha", want.alpha, rgba_ch.alpha);
        end
    endtask

    initial
    begin
        rgba_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rgba_ch.valid && rgba_ch.ready)
                check_rgba();
            rgba_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
        end
    end

    // valid stays up on return; the next send or a drain decides what follows
    task automatic send_pixel(input logic [31:0] pixel_word);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 33)
            begin
                pix_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= pixel_word;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        expected_rgba.push_back(pixel_to_rgba(pixel_word));
    endtask

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rgba.size() != 0);
    endtask

    task automatic write_mask(input logic [mpr_pkg::IDX_W-1:0] index,
                              input mpr_pkg::mask_t data);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        unique case (index)
            mpr_pkg::REG_RED_MASK:   red_mask_q   = data;
            mpr_pkg::REG_GREEN_MASK: green_mask_q = data;
            mpr_pkg::REG_BLUE_MASK:  blue_mask_q  = data;
            default: ;
        endcase
    endtask

    task automatic write_masks(input mpr_pkg::mask_t r, input mpr_pkg::mask_t g,
                               input mpr_pkg::mask_t b);
        write_mask(mpr_pkg::REG_RED_MASK, r);
        write_mask(mpr_pkg::REG_GREEN_MASK, g);
        write_mask(mpr_pkg::REG_BLUE_MASK, b);
    endtask

    task automatic test_reset_masks();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_8040);
        send_pixel(32'h1234_5678);
    endtask

    task automatic test_packed_formats();
        write_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0000_8410);
        send_pixel(32'hFFFF_7BEF);
        write_masks(32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF);
        send_pixel(32'h2008_0200);
        send_pixel(32'hC00F_FC01);
    endtask

    // empty, full-word and single top-bit masks
    task automatic test_mask_extremes();
        write_masks(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8000_0000);
        send_pixel(32'h7FFF_FFFF);
    endtask

    task automatic test_gapped_masks();
        write_masks(32'hA500_0000, 32'h00F0_F000, 32'h0000_0101);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5A0F_0F10);
        send_pixel(32'hA500_F001);
        send_pixel(32'h2400_8100);
    endtask

    task automatic test_ignored_index();
        write_masks(mpr_pkg::RED_MASK_RST, mpr_pkg::GREEN_MASK_RST, mpr_pkg::BLUE_MASK_RST);
        write_mask(REG_SPARE_INDEX, 32'hFFFF_FFFF);
        send_pixel(32'h0080_FF01);
        write_mask(REG_SPARE_INDEX, 32'h0000_0000);
        send_pixel(32'hFF7F_0180);
        send_pixel(32'h00AA_55CC);
    endtask

    task automatic test_random_masks(input int rounds, input int items);
        repeat (rounds)
        begin
            write_masks(random_mask(), random_mask(), random_mask());
            repeat (items)
                send_pixel(random_pixel());
        end
    endtask

    // back-to-back items with the output never stalled
    task automatic test_steady_stream();
        write_masks(random_mask(), random_mask(), random_mask());
        steady = 1'b1;
        repeat (100)
            send_pixel(random_pixel());
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        write_masks(random_mask(), random_mask(), random_mask());
        repeat (4)
        begin
            repeat (25)
                send_pixel(random_pixel());
            wait_drained();
        end
    endtask

    initial
    begin
        errors = 0;
        steady = 1'b0;
        red_mask_q   = mpr_pkg::RED_MASK_RST;
        green_mask_q = mpr_pkg::GREEN_MASK_RST;
        blue_mask_q  = mpr_pkg::BLUE_MASK_RST;
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= mpr_pkg::REG_RED_MASK;
        cfg_data     <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_masks();
        test_packed_formats();
        test_mask_extremes();
        test_gapped_masks();
        test_ignored_index();
        test_random_masks(15, 50);
        test_steady_stream();
        test_drain_pause();

        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("masked_pixel_to_rgba8 regression: pass");
        else
            $display("masked_pixel_to_rgba8 regression: fail");
        $finish;
    end

endmodule

@@ masked_pixel_to_rgba8.f @@
hdl/mpr_pkg.sv
hdl/mpr_pixel_if.sv
hdl/mpr_rgba_if.sv
hdl/mpr_unpack.sv
hdl/mpr_numer.sv
hdl/mpr_div_step.sv
hdl/masked_pixel_to_rgba8.sv
verif/masked_pixel_to_rgba8_tb.sv
